/* hw/rtl/psm_pkg.sv */
package psm_pkg;

	// machine geometry
	localparam int WORD_BITS   = 32;
	localparam int CODE_DEPTH  = 256;
	localparam int STACK_DEPTH = 512;
	localparam int LEVEL_MAX   = 3;

	localparam int CODE_AW  = $clog2(CODE_DEPTH);
	localparam int STACK_AW = $clog2(STACK_DEPTH);
	localparam int DIV_CW   = $clog2(WORD_BITS);
	localparam int EXT_BITS = WORD_BITS + 2;

	// field widths on the ports
	localparam int PC_BITS  = 8;
	localparam int TOP_BITS = 9;
	localparam int ARG_BITS = 32;

	localparam logic [STACK_AW-1:0] TOP_LAST = STACK_AW'(STACK_DEPTH - 1);

	// request kinds
	localparam logic [1:0] KIND_LOAD    = 2'd0;
	localparam logic [1:0] KIND_STEP    = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;

	// fault codes
	localparam logic [1:0] FAULT_NONE   = 2'd0;
	localparam logic [1:0] FAULT_DIV0   = 2'd1;
	localparam logic [1:0] FAULT_RANGE  = 2'd2;
	localparam logic [1:0] FAULT_HALTED = 2'd3;

	// OPR sub-operations
	localparam int OPR_RET = 0;
	localparam int OPR_NEG = 1;
	localparam int OPR_ADD = 2;
	localparam int OPR_SUB = 3;
	localparam int OPR_MUL = 4;
	localparam int OPR_DIV = 5;
	localparam int OPR_ODD = 6;
	localparam int OPR_EQ  = 8;
	localparam int OPR_NE  = 9;
	localparam int OPR_LT  = 10;
	localparam int OPR_GE  = 11;
	localparam int OPR_GT  = 12;
	localparam int OPR_LE  = 13;
	localparam int OPR_RD  = 16;
	localparam int OPR_WR  = 17;

	typedef enum logic [2:0] {
		OP_LIT, OP_OPR, OP_LOD, OP_STO, OP_CAL, OP_INT, OP_JMP, OP_JPC
	} op_t;

	typedef struct packed {
		logic signed [ARG_BITS-1:0] arg;
		logic [1:0]                 level;
		op_t                        func;
	} insn_t;

	localparam int INSN_BITS = $bits(insn_t);

	typedef struct packed {
		logic [1:0]                  kind;
		logic [7:0]                  code_addr;
		logic [2:0]                  op_func;
		logic [1:0]                  op_level;
		logic signed [ARG_BITS-1:0]  op_arg;
		logic signed [WORD_BITS-1:0] read_value;
	} req_t;

	typedef struct packed {
		logic [PC_BITS-1:0]          pc_next;
		logic [TOP_BITS-1:0]         top_index;
		logic signed [WORD_BITS-1:0] top_value;
		logic                        read_taken;
		logic                        write_valid;
		logic signed [WORD_BITS-1:0] write_value;
		logic                        halted;
		logic [1:0]                  fault;
	} rsp_t;

	// sign-extend a word to the wide address domain
	function automatic logic signed [EXT_BITS-1:0] sext_word(input logic [WORD_BITS-1:0] w);
		return {{2{w[WORD_BITS-1]}}, w};
	endfunction

	// true when a wide signed index lies inside the stack
	function automatic logic in_stack(input logic signed [EXT_BITS-1:0] x);
		return !x[EXT_BITS-1] && (x < EXT_BITS'(STACK_DEPTH));
	endfunction

endpackage

/* hw/rtl/psm_ram.sv */
module psm_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port, data held between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/psm_div.sv */
module psm_div import psm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] dividend,
	input  logic [WORD_BITS-1:0] divisor,
	output logic                 done,
	output logic [WORD_BITS-1:0] quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic                 neg_q;
	logic [DIV_CW-1:0]    cnt_q;
	logic [WORD_BITS-1:0] quo_q;
	logic [WORD_BITS-1:0] dvs_q;
	logic [WORD_BITS:0]   rem_q;
	logic [WORD_BITS:0]   shifted;
	logic                 fits;

	// one restoring step per cycle on magnitudes
	assign shifted = {rem_q[WORD_BITS-1:0], quo_q[WORD_BITS-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				neg_q  <= dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
				quo_q  <= dividend[WORD_BITS-1] ? -dividend : dividend;
				dvs_q  <= divisor[WORD_BITS-1] ? -divisor : divisor;
				rem_q  <= '0;
				cnt_q  <= DIV_CW'(WORD_BITS - 1);
			end else if (busy_q) begin
				rem_q <= fits ? shifted - {1'b0, dvs_q} : shifted;
				quo_q <= {quo_q[WORD_BITS-2:0], fits};
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// truncation toward zero: apply the sign to the magnitude
	assign done     = done_q;
	assign quotient = neg_q ? -quo_q : quo_q;

endmodule

/* hw/rtl/pcode_stack_machine_core.sv */
// Channel | Dir | Type  | Handshake
// req     | in  | req_t | req_valid / req_ready
// rsp     | out | rsp_t | rsp_valid / rsp_ready
//
// One request at a time; each gives one response after its own sequence.
// Load and unknown kinds go straight to the top-of-stack read; restart first clears
// three stack words. A step's length depends on its instruction and on the static links
// followed; the stack memory's single read port sets this. Divide waits on the divider.
// After reset a pass zeroes stack words 1 to 3 before requests are taken.
// A stalled response waits in its register; the next request is taken meanwhile.
module pcode_stack_machine_core import psm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_DEC, S_WALK, S_LINK, S_RD1, S_RD2, S_DIV,
		S_CAL2, S_CAL3, S_TOP, S_OUT
	} state_t;

	state_t state_q, state_d;

	logic [CODE_AW-1:0]   pc_q, pc_d;
	logic [STACK_AW-1:0]  base_q, base_d;
	logic [STACK_AW-1:0]  top_q, top_d;
	logic                 halt_q, halt_d;
	logic [1:0]           clr_q, clr_d;
	logic                 clr_out_q, clr_out_d;
	logic [1:0]           lev_q, lev_d;
	logic [WORD_BITS-1:0] wb_q, wb_d;
	logic [WORD_BITS-1:0] x_q, x_d;
	logic [STACK_AW-1:0]  adr_q, adr_d;
	logic [WORD_BITS-1:0] rd_q, rd_d;
	logic                 rtaken_q, rtaken_d;
	logic                 wvalid_q, wvalid_d;
	logic [WORD_BITS-1:0] wval_q, wval_d;
	logic [1:0]           fault_q, fault_d;
	logic                 rsp_valid_q, rsp_valid_d;
	rsp_t                 rsp_q, rsp_d;

	// memory ports
	logic                 code_we, code_re;
	logic [CODE_AW-1:0]   code_waddr;
	logic [INSN_BITS-1:0] code_wdata, code_rdata;
	logic                 stk_we, stk_re;
	logic [STACK_AW-1:0]  stk_waddr, stk_raddr;
	logic [WORD_BITS-1:0] stk_wdata, stk_rdata;

	logic                 div_start, div_done;
	logic [WORD_BITS-1:0] div_quo;

	// decoded instruction, held in the code read register for the whole step
	insn_t                      insn;
	op_t                        op;
	logic signed [ARG_BITS-1:0] arg;
	logic [1:0]                 lev;
	logic                       opr_bin;

	logic [CODE_AW-1:0]           np_inc;
	logic [STACK_AW-1:0]          top_inc, top_inc2, top_inc3, top_dec;
	logic [STACK_AW-1:0]          base_inc, base_inc2, base_dec;
	logic signed [EXT_BITS-1:0]   int_sum, daddr;
	logic [WORD_BITS-1:0]         alu_r;

	logic                 commit;
	logic [CODE_AW-1:0]   np_c;
	logic                 fault_set;
	logic [1:0]           fault_code;

	assign insn    = insn_t'(code_rdata);
	assign op      = insn.func;
	assign arg     = insn.arg;
	assign lev     = (insn.level > 2'(LEVEL_MAX)) ? 2'(LEVEL_MAX) : insn.level;
	assign opr_bin = arg inside {[OPR_ADD:OPR_DIV], [OPR_EQ:OPR_LE]};

	assign np_inc    = pc_q + 1'b1;
	assign top_inc   = top_q + 1'b1;
	assign top_inc2  = top_q + STACK_AW'(2);
	assign top_inc3  = top_q + STACK_AW'(3);
	assign top_dec   = top_q - 1'b1;
	assign base_inc  = base_q + 1'b1;
	assign base_inc2 = base_q + STACK_AW'(2);
	assign base_dec  = base_q - 1'b1;

	assign int_sum = EXT_BITS'({1'b0, top_q}) + EXT_BITS'(arg);
	assign daddr   = sext_word(wb_q) + EXT_BITS'(arg);

	// binary OPR on x (second from top) and y (top)
	always_comb begin
		case (arg)
			OPR_ADD: alu_r = x_q + stk_rdata;
			OPR_SUB: alu_r = x_q - stk_rdata;
			OPR_MUL: alu_r = x_q * stk_rdata;
			OPR_EQ:  alu_r = WORD_BITS'(x_q == stk_rdata);
			OPR_NE:  alu_r = WORD_BITS'(x_q != stk_rdata);
			OPR_LT:  alu_r = WORD_BITS'($signed(x_q) < $signed(stk_rdata));
			OPR_GE:  alu_r = WORD_BITS'($signed(x_q) >= $signed(stk_rdata));
			OPR_GT:  alu_r = WORD_BITS'($signed(x_q) > $signed(stk_rdata));
			OPR_LE:  alu_r = WORD_BITS'($signed(x_q) <= $signed(stk_rdata));
			default: alu_r = '0;
		endcase
	end

	psm_ram #(.DEPTH(CODE_DEPTH), .WIDTH(INSN_BITS)) u_code (
		.clk   (clk),
		.we    (code_we),
		.waddr (code_waddr),
		.wdata (code_wdata),
		.re    (code_re),
		.raddr (pc_q),
		.rdata (code_rdata)
	);

	psm_ram #(.DEPTH(STACK_DEPTH), .WIDTH(WORD_BITS)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	psm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (x_q),
		.divisor  (stk_rdata),
		.done     (div_done),
		.quotient (div_quo)
	);

	// sequencer next state
	always_comb begin
		state_d     = state_q;
		pc_d        = pc_q;
		base_d      = base_q;
		top_d       = top_q;
		halt_d      = halt_q;
		clr_d       = clr_q;
		clr_out_d   = clr_out_q;
		lev_d       = lev_q;
		wb_d        = wb_q;
		x_d         = x_q;
		adr_d       = adr_q;
		rd_d        = rd_q;
		rtaken_d    = rtaken_q;
		wvalid_d    = wvalid_q;
		wval_d      = wval_q;
		fault_d     = fault_q;
		rsp_valid_d = rsp_valid_q && !rsp_ready;
		rsp_d       = rsp_q;
		code_we     = 1'b0;
		code_re     = 1'b0;
		code_waddr  = req.code_addr[CODE_AW-1:0];
		code_wdata  = {req.op_arg, req.op_level, req.op_func};
		stk_we      = 1'b0;
		stk_waddr   = top_q;
		stk_wdata   = '0;
		stk_re      = 1'b0;
		stk_raddr   = top_q;
		div_start   = 1'b0;
		commit      = 1'b0;
		np_c        = np_inc;
		fault_set   = 1'b0;
		fault_code  = FAULT_RANGE;
		req_ready   = (state_q == S_IDLE);

		case (state_q)
			// zero stack words 1 to 3
			S_CLR: begin
				stk_we    = 1'b1;
				stk_waddr = STACK_AW'(clr_q);
				if (clr_q == 2'd3) begin
					state_d = clr_out_q ? S_TOP : S_IDLE;
				end else begin
					clr_d = clr_q + 1'b1;
				end
			end

			S_IDLE: begin
				if (req_valid) begin
					rd_d     = req.read_value;
					rtaken_d = 1'b0;
					wvalid_d = 1'b0;
					wval_d   = '0;
					fault_d  = FAULT_NONE;
					case (req.kind)
						KIND_LOAD: begin
							code_we = 1'b1;
							state_d = S_TOP;
						end
						KIND_STEP: begin
							if (halt_q) begin
								fault_set  = 1'b1;
								fault_code = FAULT_HALTED;
							end else begin
								code_re = 1'b1;
								state_d = S_DEC;
							end
						end
						KIND_RESTART: begin
							pc_d      = '0;
							top_d     = '0;
							base_d    = STACK_AW'(1);
							halt_d    = 1'b0;
							clr_d     = 2'd1;
							clr_out_d = 1'b1;
							state_d   = S_CLR;
						end
						default: state_d = S_TOP;
					endcase
				end
			end

			// checks that need only registers, first memory access
			S_DEC: begin
				case (op)
					OP_LIT: begin
						if (top_q == TOP_LAST) begin
							fault_set = 1'b1;
						end else begin
							stk_we    = 1'b1;
							stk_waddr = top_inc;
							stk_wdata = arg;
							top_d     = top_inc;
							commit    = 1'b1;
						end
					end
					OP_OPR: begin
						if (arg == OPR_RET) begin
							if (base_q == '0 || base_q >= STACK_AW'(STACK_DEPTH - 2)) begin
								fault_set = 1'b1;
							end else begin
								stk_re    = 1'b1;
								stk_raddr = base_inc;
								state_d   = S_RD1;
							end
						end else if (arg == OPR_NEG || arg == OPR_ODD) begin
							stk_re  = 1'b1;
							state_d = S_RD1;
						end else if (arg == OPR_WR || opr_bin) begin
							if (top_q == '0) begin
								fault_set = 1'b1;
							end else begin
								stk_re    = 1'b1;
								stk_raddr = (arg == OPR_WR) ? top_q : top_dec;
								state_d   = S_RD1;
							end
						end else if (arg == OPR_RD) begin
							if (top_q == TOP_LAST) begin
								fault_set = 1'b1;
							end else begin
								stk_we    = 1'b1;
								stk_waddr = top_inc;
								stk_wdata = rd_q;
								rtaken_d  = 1'b1;
								top_d     = top_inc;
								commit    = 1'b1;
							end
						end else begin
							commit = 1'b1;
						end
					end
					OP_LOD, OP_STO, OP_CAL: begin
						if ((op == OP_LOD && top_q == TOP_LAST) ||
						    (op == OP_STO && top_q == '0) ||
						    (op == OP_CAL && top_q >= STACK_AW'(STACK_DEPTH - 3))) begin
							fault_set = 1'b1;
						end else begin
							wb_d    = WORD_BITS'(base_q);
							lev_d   = lev;
							state_d = S_WALK;
						end
					end
					OP_INT: begin
						if (in_stack(int_sum)) begin
							top_d  = int_sum[STACK_AW-1:0];
							commit = 1'b1;
						end else begin
							fault_set = 1'b1;
						end
					end
					OP_JMP: begin
						np_c   = arg[CODE_AW-1:0];
						commit = 1'b1;
					end
					OP_JPC: begin
						if (top_q == '0) begin
							fault_set = 1'b1;
						end else begin
							stk_re  = 1'b1;
							state_d = S_RD1;
						end
					end
					default: commit = 1'b1;
				endcase
			end

			// static link walk, then address use
			S_WALK: begin
				if (lev_q != '0) begin
					if (!in_stack(sext_word(wb_q))) begin
						fault_set = 1'b1;
					end else begin
						stk_re    = 1'b1;
						stk_raddr = wb_q[STACK_AW-1:0];
						lev_d     = lev_q - 1'b1;
						state_d   = S_LINK;
					end
				end else if (op == OP_CAL) begin
					stk_we    = 1'b1;
					stk_waddr = top_inc;
					stk_wdata = wb_q;
					state_d   = S_CAL2;
				end else if (!in_stack(daddr)) begin
					fault_set = 1'b1;
				end else begin
					stk_re  = 1'b1;
					adr_d   = daddr[STACK_AW-1:0];
					state_d = S_RD1;
					if (op == OP_LOD) begin
						stk_raddr = daddr[STACK_AW-1:0];
					end
				end
			end

			S_LINK: begin
				wb_d    = stk_rdata;
				state_d = S_WALK;
			end

			// first read data available
			S_RD1: begin
				case (op)
					OP_OPR: begin
						if (arg == OPR_RET || opr_bin) begin
							x_d       = stk_rdata;
							stk_re    = 1'b1;
							stk_raddr = (arg == OPR_RET) ? base_inc2 : top_q;
							state_d   = S_RD2;
						end else if (arg == OPR_NEG) begin
							stk_we    = 1'b1;
							stk_wdata = -stk_rdata;
							commit    = 1'b1;
						end else if (arg == OPR_ODD) begin
							stk_we    = 1'b1;
							stk_wdata = {{(WORD_BITS-1){1'b0}}, stk_rdata[0]};
							commit    = 1'b1;
						end else begin
							wvalid_d = 1'b1;
							wval_d   = stk_rdata;
							top_d    = top_dec;
							commit   = 1'b1;
						end
					end
					OP_LOD: begin
						stk_we    = 1'b1;
						stk_waddr = top_inc;
						stk_wdata = stk_rdata;
						top_d     = top_inc;
						commit    = 1'b1;
					end
					OP_STO: begin
						stk_we    = 1'b1;
						stk_waddr = adr_q;
						stk_wdata = stk_rdata;
						top_d     = top_dec;
						commit    = 1'b1;
					end
					OP_JPC: begin
						if (stk_rdata == '0) begin
							np_c = arg[CODE_AW-1:0];
						end
						top_d  = top_dec;
						commit = 1'b1;
					end
					default: state_d = S_TOP;
				endcase
			end

			// second read data available
			S_RD2: begin
				if (arg == OPR_RET) begin
					if (!in_stack(sext_word(x_q))) begin
						fault_set = 1'b1;
					end else begin
						base_d = x_q[STACK_AW-1:0];
						top_d  = base_dec;
						np_c   = stk_rdata[CODE_AW-1:0];
						commit = 1'b1;
					end
				end else if (arg == OPR_DIV) begin
					if (stk_rdata == '0) begin
						fault_set  = 1'b1;
						fault_code = FAULT_DIV0;
					end else begin
						div_start = 1'b1;
						state_d   = S_DIV;
					end
				end else begin
					stk_we    = 1'b1;
					stk_waddr = top_dec;
					stk_wdata = alu_r;
					top_d     = top_dec;
					commit    = 1'b1;
				end
			end

			S_DIV: begin
				if (div_done) begin
					stk_we    = 1'b1;
					stk_waddr = top_dec;
					stk_wdata = div_quo;
					top_d     = top_dec;
					commit    = 1'b1;
				end
			end

			// call frame: static link written in the walk, then dynamic link, return pc
			S_CAL2: begin
				stk_we    = 1'b1;
				stk_waddr = top_inc2;
				stk_wdata = WORD_BITS'(base_q);
				state_d   = S_CAL3;
			end

			S_CAL3: begin
				stk_we    = 1'b1;
				stk_waddr = top_inc3;
				stk_wdata = WORD_BITS'(np_inc);
				base_d    = top_inc;
				np_c      = arg[CODE_AW-1:0];
				commit    = 1'b1;
			end

			S_TOP: begin
				stk_re  = 1'b1;
				state_d = S_OUT;
			end

			S_OUT: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_d.pc_next     = PC_BITS'(pc_q);
					rsp_d.top_index   = TOP_BITS'(top_q);
					rsp_d.top_value   = stk_rdata;
					rsp_d.read_taken  = rtaken_q;
					rsp_d.write_valid = wvalid_q;
					rsp_d.write_value = wval_q;
					rsp_d.halted      = halt_q;
					rsp_d.fault       = fault_q;
					rsp_valid_d       = 1'b1;
					state_d           = S_IDLE;
				end
			end

			default: state_d = S_IDLE;
		endcase

		// instruction retires: new pc, halt when it comes back to zero
		if (commit) begin
			pc_d    = np_c;
			halt_d  = halt_q | (np_c == '0);
			state_d = S_TOP;
		end

		// fault: machine state untouched, halt
		if (fault_set) begin
			fault_d  = fault_code;
			halt_d   = 1'b1;
			rtaken_d = 1'b0;
			wvalid_d = 1'b0;
			wval_d   = '0;
			state_d  = S_TOP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			pc_q        <= '0;
			base_q      <= STACK_AW'(1);
			top_q       <= '0;
			halt_q      <= 1'b0;
			clr_q       <= 2'd1;
			clr_out_q   <= 1'b0;
			lev_q       <= '0;
			wb_q        <= '0;
			x_q         <= '0;
			adr_q       <= '0;
			rd_q        <= '0;
			rtaken_q    <= 1'b0;
			wvalid_q    <= 1'b0;
			wval_q      <= '0;
			fault_q     <= FAULT_NONE;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			state_q     <= state_d;
			pc_q        <= pc_d;
			base_q      <= base_d;
			top_q       <= top_d;
			halt_q      <= halt_d;
			clr_q       <= clr_d;
			clr_out_q   <= clr_out_d;
			lev_q       <= lev_d;
			wb_q        <= wb_d;
			x_q         <= x_d;
			adr_q       <= adr_d;
			rd_q        <= rd_d;
			rtaken_q    <= rtaken_d;
			wvalid_q    <= wvalid_d;
			wval_q      <= wval_d;
			fault_q     <= fault_d;
			rsp_valid_q <= rsp_valid_d;
			rsp_q       <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* dv/pcode_stack_machine_checker.sv */
`timescale 1ns / 1ps

// Watches both channels, keeps its own copy of the machine state and checks
// every response against the oldest outstanding prediction.
module pcode_stack_machine_checker import psm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp,
	output int   errors,
	output int   pending
);

	typedef struct {
		rsp_t r;
		bit   top_known;
	} due_t;

	// shadow machine
	insn_t          prog [CODE_DEPTH];
	logic [31:0]    stk [STACK_DEPTH];
	bit             stk_set [STACK_DEPTH];
	logic [7:0]     pc;
	int             base;
	int             top;
	bit             halt;

	due_t due [$];

	assign pending = due.size();

	function automatic bit in_rng(longint x);
		return x >= 0 && x < STACK_DEPTH;
	endfunction

	function automatic longint sval(int i);
		return longint'($signed(stk[i]));
	endfunction

	function automatic void put(int i, logic [31:0] v);
		stk[i] = v;
		stk_set[i] = 1'b1;
	endfunction

	// follow static links from b
	function automatic bit walk(int b, int lev, output longint res);
		longint b1;
		b1 = b;
		for (int i = 0; i < lev; i++) begin
			if (!in_rng(b1))
				return 1'b0;
			b1 = sval(int'(b1));
		end
		res = b1;
		return 1'b1;
	endfunction

	function automatic bit frame_addr(int b, int lev, longint off, output int addr);
		longint b1;
		if (!walk(b, lev, b1))
			return 1'b0;
		if (!in_rng(b1 + off))
			return 1'b0;
		addr = int'(b1 + off);
		return 1'b1;
	endfunction

	// one instruction; returns the fault code, commits only on success
	function automatic logic [1:0] exec_insn(input logic [31:0] rd, output bit rt,
			output bit wv, output logic [31:0] wval);
		insn_t       ins;
		int          b, t, nt, addr;
		longint      a, b1, nb, x, y;
		logic [7:0]  np;
		logic [31:0] r;
		ins = prog[pc];
		b = base;
		t = top;
		a = longint'(ins.arg);
		np = pc + 8'd1;
		rt = 0;
		wv = 0;
		wval = '0;
		case (ins.func)
			OP_LIT: begin
				if (t + 1 >= STACK_DEPTH) return FAULT_RANGE;
				t++;
				put(t, ins.arg);
			end
			OP_OPR: begin
				case (a)
					OPR_RET: begin
						nt = b - 1;
						if (nt < 0 || nt + 3 >= STACK_DEPTH) return FAULT_RANGE;
						nb = sval(nt + 2);
						if (!in_rng(nb)) return FAULT_RANGE;
						np = stk[nt + 3][7:0];
						t = nt;
						b = int'(nb);
					end
					OPR_NEG: put(t, -stk[t]);
					OPR_ODD: put(t, {31'd0, stk[t][0]});
					OPR_RD: begin
						if (t + 1 >= STACK_DEPTH) return FAULT_RANGE;
						t++;
						put(t, rd);
						rt = 1;
					end
					OPR_WR: begin
						if (t < 1) return FAULT_RANGE;
						wv = 1;
						wval = stk[t];
						t--;
					end
					OPR_ADD, OPR_SUB, OPR_MUL, OPR_DIV, OPR_EQ, OPR_NE, OPR_LT, OPR_GE,
					OPR_GT, OPR_LE: begin
						if (t < 1) return FAULT_RANGE;
						x = sval(t - 1);
						y = sval(t);
						case (a)
							OPR_ADD: r = stk[t-1] + stk[t];
							OPR_SUB: r = stk[t-1] - stk[t];
							OPR_MUL: r = stk[t-1] * stk[t];
							OPR_DIV: begin
								if (y == 0) return FAULT_DIV0;
								r = (y == -1) ? -stk[t-1] : 32'(x / y);
							end
							OPR_EQ:  r = 32'(x == y);
							OPR_NE:  r = 32'(x != y);
							OPR_LT:  r = 32'(x < y);
							OPR_GE:  r = 32'(x >= y);
							OPR_GT:  r = 32'(x > y);
							default: r = 32'(x <= y);
						endcase
						t--;
						put(t, r);
					end
					default: ;
				endcase
			end
			OP_LOD: begin
				if (t + 1 >= STACK_DEPTH) return FAULT_RANGE;
				if (!frame_addr(b, ins.level, a, addr)) return FAULT_RANGE;
				put(t + 1, stk[addr]);
				t++;
			end
			OP_STO: begin
				if (t < 1) return FAULT_RANGE;
				if (!frame_addr(b, ins.level, a, addr)) return FAULT_RANGE;
				put(addr, stk[t]);
				t--;
			end
			OP_CAL: begin
				if (t + 3 >= STACK_DEPTH) return FAULT_RANGE;
				if (!walk(b, ins.level, b1)) return FAULT_RANGE;
				put(t + 1, 32'(b1));
				put(t + 2, 32'(b));
				put(t + 3, {24'd0, np});
				b = t + 1;
				np = ins.arg[7:0];
			end
			OP_INT: begin
				if (!in_rng(t + a)) return FAULT_RANGE;
				t = int'(t + a);
			end
			OP_JMP: np = ins.arg[7:0];
			default: begin
				if (t < 1) return FAULT_RANGE;
				if (stk[t] == '0)
					np = ins.arg[7:0];
				t--;
			end
		endcase
		pc = np;
		base = b;
		top = t;
		if (np == 8'd0)
			halt = 1'b1;
		return FAULT_NONE;
	endfunction

	function automatic due_t predict(req_t q);
		due_t        d;
		logic [1:0]  flt;
		bit          rt, wv;
		logic [31:0] wval;
		flt = FAULT_NONE;
		rt = 0;
		wv = 0;
		wval = '0;
		case (q.kind)
			KIND_LOAD: prog[q.code_addr] = insn_t'({q.op_arg, q.op_level, q.op_func});
			KIND_RESTART: begin
				pc = '0;
				top = 0;
				base = 1;
				for (int i = 1; i <= 3; i++)
					put(i, '0);
				halt = 1'b0;
			end
			KIND_STEP: begin
				if (halt)
					flt = FAULT_HALTED;
				else begin
					flt = exec_insn(q.read_value, rt, wv, wval);
					if (flt != FAULT_NONE) begin
						rt = 0;
						wv = 0;
						wval = '0;
						halt = 1'b1;
					end
				end
			end
			default: ;
		endcase
		d.r.pc_next     = pc;
		d.r.top_index   = TOP_BITS'(top);
		d.r.top_value   = stk[top];
		d.r.read_taken  = rt;
		d.r.write_valid = wv;
		d.r.write_value = wval;
		d.r.halted      = halt;
		d.r.fault       = flt;
		d.top_known     = stk_set[top];
		return d;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	// sample both channels at the clock edge
	always @(posedge clk or negedge arst_n) begin
		due_t d;
		if (!arst_n) begin
			errors = 0;
			due.delete();
			pc = '0;
			base = 1;
			top = 0;
			halt = 1'b0;
			for (int i = 0; i < STACK_DEPTH; i++)
				stk_set[i] = (i >= 1 && i <= 3);
			for (int i = 1; i <= 3; i++)
				stk[i] = '0;
		end else begin
			if (req_valid && req_ready)
				due.push_back(predict(req));
			if (rsp_valid && rsp_ready) begin
				if (due.size() == 0)
					report("unexpected response", 64'(rsp), '0);
				else begin
					d = due.pop_front();
					if (rsp.pc_next != d.r.pc_next)
						report("pc_next", rsp.pc_next, d.r.pc_next);
					if (rsp.top_index != d.r.top_index)
						report("top_index", rsp.top_index, d.r.top_index);
					if (d.top_known && rsp.top_value !== d.r.top_value)
						report("top_value", rsp.top_value, d.r.top_value);
					if (rsp.read_taken !== d.r.read_taken)
						report("read_taken", rsp.read_taken, d.r.read_taken);
					if (rsp.write_valid !== d.r.write_valid)
						report("write_valid", rsp.write_valid, d.r.write_valid);
					if (rsp.write_value !== d.r.write_value)
						report("write_value", rsp.write_value, d.r.write_value);
					if (rsp.halted !== d.r.halted)
						report("halted", rsp.halted, d.r.halted);
					if (rsp.fault !== d.r.fault)
						report("fault", rsp.fault, d.r.fault);
				end
			end
		end
	end

endmodule

/* dv/pcode_stack_machine_core_tb.sv */
`timescale 1ns / 1ps

module pcode_stack_machine_core_tb import psm_pkg::*; ;

	localparam int IDLE_LIMIT = 4000;
	localparam int RAND_REQS  = 1350;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	int   errors, pending;
	int   idle = 0;
	bit   calm = 1'b0;
	int   sent = 0;

	pcode_stack_machine_core dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	pcode_stack_machine_checker chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.errors(errors), .pending(pending)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// response side back-pressure
	initial begin
		int k;
		@(posedge arst_n);
		forever begin
			k = calm ? 0 : $urandom_range(0, 7);
			if (k > 0) begin
				rsp_ready <= 1'b0;
				repeat (k) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
		end
	end

	// no progress on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle <= 0;
			else
				idle <= idle + 1;
			if (idle == IDLE_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	task automatic send(req_t r);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		sent++;
	endtask

	function automatic req_t noise_req(logic [1:0] kind);
		req_t r;
		r = req_t'({$urandom, $urandom, $urandom});
		r.kind = kind;
		return r;
	endfunction

	task automatic load(int addr, op_t f, int lev, int arg);
		req_t r;
		r = noise_req(KIND_LOAD);
		r.code_addr = addr[7:0];
		r.op_func = f;
		r.op_level = lev[1:0];
		r.op_arg = arg;
		send(r);
	endtask

	task automatic step(int rd);
		req_t r;
		r = noise_req(KIND_STEP);
		r.read_value = rd;
		send(r);
	endtask

	task automatic restart();
		send(noise_req(KIND_RESTART));
	endtask

	// mostly sane instruction for a program living at 0..n-1
	task automatic load_rand_insn(int addr, int n);
		int   arg, lev, pick;
		op_t  f;
		int   oprs [12] = '{OPR_RET, OPR_NEG, OPR_ADD, OPR_SUB, OPR_MUL, OPR_DIV, OPR_ODD,
			OPR_EQ, OPR_NE, OPR_LT, OPR_GE, OPR_GT};
		pick = $urandom_range(0, 19);
		lev = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 0;
		if (pick < 5) begin
			f = OP_LIT;
			arg = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 9) - 4;
		end else if (pick < 11) begin
			f = OP_OPR;
			case ($urandom_range(0, 9))
				0: arg = OPR_RD;
				1: arg = OPR_WR;
				2: arg = OPR_LE;
				3: arg = $urandom_range(0, 31);
				default: arg = oprs[$urandom_range(0, 11)];
			endcase
		end else if (pick < 15) begin
			f = (pick < 13) ? OP_LOD : OP_STO;
			arg = $urandom_range(0, 9) - 3;
		end else begin
			f = op_t'($urandom_range(4, 7));
			arg = (f == OP_INT) ? $urandom_range(0, 5) : $urandom_range(1, n - 1);
		end
		if ($urandom_range(0, 15) == 0)
			arg = $urandom;
		load(addr, f, lev, arg);
	endtask

	initial begin
		int n, s;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// whole code image: stack filler at 100, directed routine at 40
		for (int i = 0; i < CODE_DEPTH; i++) begin
			if (i == 0)
				load(i, OP_JMP, 0, 100);
			else if (i == 100)
				load(i, OP_LIT, 0, 7);
			else if (i == 101)
				load(i, OP_STO, 0, -1);
			else if (i >= 102 && i < 134)
				load(i, OP_LIT, 0, $urandom);
			else if (i == 134)
				load(i, OP_JMP, 0, 102);
			else
				case (i)
					40: load(i, OP_INT, 0, 4);
					41: load(i, OP_LIT, 0, 32'h7fff_ffff);
					42: load(i, OP_LIT, 0, 1);
					43: load(i, OP_OPR, 0, OPR_ADD);
					44: load(i, OP_LIT, 0, -1);
					45: load(i, OP_OPR, 0, OPR_DIV);
					46: load(i, OP_OPR, 0, OPR_RD);
					47: load(i, OP_OPR, 0, OPR_ODD);
					48: load(i, OP_OPR, 0, OPR_SUB);
					49: load(i, OP_OPR, 0, OPR_NEG);
					50: load(i, OP_LIT, 0, 3);
					51: load(i, OP_OPR, 0, OPR_GE);
					52: load(i, OP_CAL, 1, 60);
					53: load(i, OP_OPR, 0, 7);
					54: load(i, OP_JPC, 0, 57);
					57: load(i, OP_LIT, 0, 0);
					58: load(i, OP_OPR, 0, OPR_DIV);
					60: load(i, OP_LOD, 0, 2);
					61: load(i, OP_STO, 1, 0);
					62: load(i, OP_OPR, 0, OPR_WR);
					63: load(i, OP_OPR, 0, OPR_RET);
					default: load_rand_insn(i, CODE_DEPTH);
				endcase
		end
		// run the filler until the stack overflows; later steps hit the halted case
		calm = 1'b1;
		repeat (545) step($urandom);
		calm = 1'b0;
		req_valid <= 1'b0;

		// directed routine: wraps, divide extremes, odd of a negative, call and return,
		// write, unknown OPR, conditional jump, divide by zero, halted step, unknown kind
		while (pending != 0) @(posedge clk);
		load(0, OP_JMP, 0, 40);
		restart();
		repeat (22) step(-7);
		step(5);
		send(noise_req(2'd3));

		// random programs at 0..n-1
		while (sent < RAND_REQS) begin
			calm = ($urandom_range(0, 4) == 0);
			n = $urandom_range(4, 16);
			for (int i = 1; i < n; i++)
				load_rand_insn(i, n);
			load(0, OP_INT, 0, $urandom_range(3, 6));
			if ($urandom_range(0, 5) == 0)
				load($urandom_range(0, 255), op_t'($urandom_range(0, 7)),
					$urandom_range(0, 3), $urandom);
			restart();
			s = $urandom_range(5, 40);
			for (int i = 0; i < s; i++) begin
				if ($urandom_range(0, 40) == 0)
					send(noise_req(2'd3));
				else if ($urandom_range(0, 60) == 0)
					restart();
				else
					step($urandom);
			end
		end
		req_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
